// File: sv/crfi_pkg.sv
// crfi_pkg: item types, request and status codes, and controller states
// for the context registry and fence issuer. No dependencies.
`default_nettype none

package crfi_pkg;

   localparam int CTX_W   = 32;
   localparam int FENCE_W = 64;

   // request codes
   localparam logic [1:0] REQ_CREATE  = 2'd0;
   localparam logic [1:0] REQ_DESTROY = 2'd1;
   localparam logic [1:0] REQ_COMMAND = 2'd2;
   localparam logic [1:0] REQ_POLL    = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_INVALID     = 3'd1;
   localparam logic [2:0] ST_DUPLICATE   = 3'd2;
   localparam logic [2:0] ST_FULL        = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
   localparam logic [2:0] ST_DEVICE      = 3'd5;
   localparam logic [2:0] ST_NOT_REACHED = 3'd6;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [CTX_W-1:0]   ctx_id;
      logic               device_accept;
      logic [FENCE_W-1:0] query_fence;
      logic [FENCE_W-1:0] completed_fence;
      logic               device_error;
   } req_item_type;

   typedef struct packed {
      logic               success;
      logic [2:0]         status_code;
      logic [FENCE_W-1:0] fence_value;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_RESULT
   } state_type;

endpackage : crfi_pkg

`default_nettype wire

// File: sv/context_registry_fence_issuer.sv
// context_registry_fence_issuer: context table in a synchronous memory,
// scanned one slot per cycle, plus the 64-bit fence counter.
// Depends on crfi_pkg.
//
//   channel   dir   handshake            payload
//   req_*     in    req_valid/req_stall  req_item_type
//   rsp_*     out   rsp_valid/rsp_stall  rsp_item_type
//
// Create, destroy and command items go from accept through a table read of
// every slot via the single read port, a drain state for the last read data
// and a result state that decides and writes back. Polls and zero identifiers
// skip the scan and go straight to the result state. One item is in work at a
// time; the next is accepted while the previous result still waits on rsp_stall.
// After reset a clearing pass writes zero to every slot, during which
// req_stall is high.
`default_nettype none

module context_registry_fence_issuer
   import crfi_pkg::*;
#(
   parameter int SLOT_COUNT = 128
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_item_type  req_item,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_item_type       rsp_item
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   state_type state_ff, state_in;

   logic [CTX_W-1:0]   table_mem [SLOT_COUNT];
   logic [CTX_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_valid_ff;

   logic [IDX_W-1:0]   addr_ff, addr_in;
   req_item_type       req_ff;
   logic               match_ff, free_ff;
   logic [IDX_W-1:0]   match_idx_ff, free_idx_ff;
   logic [FENCE_W-1:0] next_fence_ff, fence_inc;

   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;

   // controller outputs
   logic               accept;
   logic               clear_we;
   logic               scan_rd;
   logic               load_rsp;
   logic               quick;

   // decision
   logic [2:0]         status;
   logic [FENCE_W-1:0] fence_out;
   logic               commit_we;
   logic [IDX_W-1:0]   commit_addr;
   logic [CTX_W-1:0]   commit_data;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [CTX_W-1:0]   mem_wdata;

   assign quick = (req_item.req_type == REQ_POLL) || (req_item.ctx_id == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (addr_ff == LAST_IDX) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = quick ? S_RESULT : S_SCAN;
         end
         S_SCAN: begin
            if (addr_ff == LAST_IDX) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // controller outputs
   always_comb begin
      req_stall = 1'b1;
      clear_we  = 1'b0;
      scan_rd   = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_CLEAR:  clear_we  = 1'b1;
         S_IDLE:   req_stall = 1'b0;
         S_SCAN:   scan_rd   = 1'b1;
         S_DRAIN:  ;
         S_RESULT: load_rsp  = !rsp_valid_ff || !rsp_stall;
         default:  ;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      addr_in = addr_ff;
      if (accept) begin
         addr_in = '0;
      end else if (clear_we || scan_rd) begin
         addr_in = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
      end
   end

   // result decision from the captured item and the scan flags
   always_comb begin
      status      = ST_OK;
      fence_out   = '0;
      commit_we   = 1'b0;
      commit_addr = free_idx_ff;
      commit_data = req_ff.ctx_id;
      if (req_ff.req_type == REQ_POLL) begin
         fence_out = req_ff.query_fence;
         if (req_ff.query_fence == '0) begin
            status    = ST_INVALID;
            fence_out = '0;
         end else if (req_ff.device_error) begin
            status = ST_DEVICE;
         end else if (req_ff.completed_fence < req_ff.query_fence) begin
            status = ST_NOT_REACHED;
         end
      end else if (req_ff.ctx_id == '0) begin
         status = ST_INVALID;
      end else if (req_ff.req_type == REQ_CREATE) begin
         if (match_ff)                   status = ST_DUPLICATE;
         else if (!free_ff)              status = ST_FULL;
         else if (!req_ff.device_accept) status = ST_DEVICE;
         else begin
            fence_out = next_fence_ff;
            commit_we = 1'b1;
         end
      end else begin
         commit_addr = match_idx_ff;
         commit_data = '0;
         if (!match_ff)                  status = ST_NOT_FOUND;
         else if (!req_ff.device_accept) status = ST_DEVICE;
         else begin
            fence_out = next_fence_ff;
            commit_we = (req_ff.req_type == REQ_DESTROY);
         end
      end
   end

   // counter skips zero on wrap
   assign fence_inc = (next_fence_ff == {FENCE_W{1'b1}}) ? FENCE_W'(1) : next_fence_ff + 1'b1;

   assign mem_we    = clear_we || (load_rsp && commit_we);
   assign mem_waddr = clear_we ? addr_ff : commit_addr;
   assign mem_wdata = clear_we ? '0 : commit_data;

   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= table_mem[addr_ff];
      rd_idx_ff  <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         addr_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         next_fence_ff <= FENCE_W'(1);
         rsp_valid_ff  <= 1'b0;
         match_ff      <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= scan_rd;
         if (accept) begin
            match_ff <= 1'b0;
            free_ff  <= 1'b0;
         end else if (rd_valid_ff) begin
            if (!match_ff && rd_data_ff == req_ff.ctx_id) match_ff <= 1'b1;
            if (!free_ff && rd_data_ff == '0)             free_ff  <= 1'b1;
         end
         if (load_rsp && status == ST_OK && req_ff.req_type != REQ_POLL) begin
            next_fence_ff <= fence_inc;
         end
         if (load_rsp)              rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)       rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_item;
      if (rd_valid_ff && !match_ff && rd_data_ff == req_ff.ctx_id) match_idx_ff <= rd_idx_ff;
      if (rd_valid_ff && !free_ff && rd_data_ff == '0)             free_idx_ff  <= rd_idx_ff;
      if (load_rsp) begin
         rsp_item_ff.success     <= (status == ST_OK);
         rsp_item_ff.status_code <= status;
         rsp_item_ff.fence_value <= fence_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule : context_registry_fence_issuer

`default_nettype wire

// File: verif/context_registry_fence_issuer_test.sv
// Self-checking bench for context_registry_fence_issuer: directed and random
// create/destroy/command/poll items against an in-bench registry predictor.
// Depends on crfi_pkg and the block's RTL.

module context_registry_fence_issuer_test;
   import crfi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = 128;
   localparam int POOL_SIZE  = 160;
   localparam int SCAN_WAIT  = SLOTS + 12;
   localparam int LONG_HOLD  = 900;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   context_registry_fence_issuer #(
      .SLOT_COUNT(SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // predictor state
   logic [CTX_W-1:0]   shadow_ctx [SLOTS];
   logic [FENCE_W-1:0] shadow_fence;

   req_item_type req_backlog[$];
   rsp_item_type awaited_replies[$];
   logic [CTX_W-1:0] id_pool [POOL_SIZE];
   logic [CTX_W-1:0] stray_ids[$];

   int   offered_count = 0;
   int   taken_count = 0;
   int   error_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_asks = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   logic req_fire = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic rsp_item_type predict_registry_reply(req_item_type r);
      rsp_item_type reply;
      int           hit;
      int           free_slot;
      logic         issue;
      hit = -1;
      free_slot = -1;
      issue = 1'b0;
      reply.status_code = ST_OK;
      reply.fence_value = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && shadow_ctx[i] == r.ctx_id) hit = i;
         if (free_slot < 0 && shadow_ctx[i] == '0) free_slot = i;
      end
      if (r.req_type == REQ_POLL) begin
         if (r.query_fence == '0) begin
            reply.status_code = ST_INVALID;
         end else begin
            reply.fence_value = r.query_fence;
            if (r.device_error) reply.status_code = ST_DEVICE;
            else if (r.completed_fence < r.query_fence) reply.status_code = ST_NOT_REACHED;
         end
      end else if (r.ctx_id == '0) begin
         // zero is never a live id, even though it marks free slots
         reply.status_code = ST_INVALID;
      end else if (r.req_type == REQ_CREATE) begin
         if (hit >= 0) reply.status_code = ST_DUPLICATE;
         else if (free_slot < 0) reply.status_code = ST_FULL;
         else if (!r.device_accept) reply.status_code = ST_DEVICE;
         else begin
            shadow_ctx[free_slot] = r.ctx_id;
            issue = 1'b1;
         end
      end else begin
         if (hit < 0) reply.status_code = ST_NOT_FOUND;
         else if (!r.device_accept) reply.status_code = ST_DEVICE;
         else begin
            if (r.req_type == REQ_DESTROY) shadow_ctx[hit] = '0;
            issue = 1'b1;
         end
      end
      if (issue) begin
         reply.fence_value = shadow_fence;
         shadow_fence = shadow_fence + 1'b1;
         if (shadow_fence == '0) shadow_fence = FENCE_W'(1);
      end
      reply.success = (reply.status_code == ST_OK);
      return reply;
   endfunction

   task automatic add_request(req_item_type r);
      req_backlog.push_back(r);
      offered_count++;
   endtask

   task automatic add_directed(logic [1:0] kind, logic [CTX_W-1:0] id, logic accept,
                               logic [FENCE_W-1:0] query, logic [FENCE_W-1:0] done_fence,
                               logic dev_err);
      req_item_type r;
      r.req_type        = kind;
      r.ctx_id          = id;
      r.device_accept   = accept;
      r.query_fence     = query;
      r.completed_fence = done_fence;
      r.device_error    = dev_err;
      add_request(r);
   endtask

   function automatic logic [CTX_W-1:0] fresh_id();
      logic [CTX_W-1:0] v;
      do v = $urandom; while (v == '0);
      return v;
   endfunction

   task automatic add_random(int count);
      req_item_type r;
      int unsigned  pick;
      for (int n = 0; n < count; n++) begin
         // unused fields stay random: the block must ignore them
         r.ctx_id          = $urandom;
         r.query_fence     = {$urandom, $urandom};
         r.completed_fence = {$urandom, $urandom};
         r.device_accept   = 1'($urandom_range(1));
         r.device_error    = 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 35) r.req_type = REQ_CREATE;
         else if (pick < 55) r.req_type = REQ_DESTROY;
         else if (pick < 80) r.req_type = REQ_COMMAND;
         else r.req_type = REQ_POLL;
         if (r.req_type == REQ_POLL) begin
            case ($urandom_range(5))
               0: r.query_fence = '0;
               1: r.completed_fence = r.query_fence;
               2: r.completed_fence = r.query_fence - $urandom_range(1, 3);
               3: r.completed_fence = r.query_fence + $urandom_range(0, 3);
               default: ;
            endcase
            r.device_error = ($urandom_range(3) == 0);
         end else begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               r.ctx_id = '0;
            end else if (pick < 20) begin
               if (r.req_type == REQ_CREATE) stray_ids.push_back(r.ctx_id);
            end else begin
               r.ctx_id = id_pool[$urandom_range(POOL_SIZE - 1)];
            end
            r.device_accept = ($urandom_range(7) != 0);
         end
         add_request(r);
      end
   endtask

   // all offered items taken by the block
   task automatic wait_all_taken();
      do @(negedge clock); while (taken_count != offered_count);
   endtask

   // all taken and every reply back
   task automatic wait_all_replied();
      do @(negedge clock); while (taken_count != offered_count || awaited_replies.size() != 0);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_item  <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // reply side stall, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor: check replies, then predict for the item taken at this edge
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_replies.size() == 0) begin
               error_count++;
               $display("%0t: reply with nothing outstanding: %p", $time, rsp_item);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_item.success !== want.success) begin
                  error_count++;
                  $display("%0t: success expected %0b got %0b", $time,
                           want.success, rsp_item.success);
               end
               if (rsp_item.status_code !== want.status_code) begin
                  error_count++;
                  $display("%0t: status_code expected %0d got %0d", $time,
                           want.status_code, rsp_item.status_code);
               end
               if (rsp_item.fence_value !== want.fence_value) begin
                  error_count++;
                  $display("%0t: fence_value expected %h got %h", $time,
                           want.fence_value, rsp_item.fence_value);
               end
            end
         end
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            awaited_replies.push_back(predict_registry_reply(req_item));
            taken_count++;
         end
      end
   end

   initial begin
      int n;
      for (int i = 0; i < SLOTS; i++) shadow_ctx[i] = '0;
      shadow_fence = FENCE_W'(1);
      for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = fresh_id();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: id and fence extremes, every status but full
      add_directed(REQ_CREATE,  '0,            1'b1, '0, '0, 1'b0);
      add_directed(REQ_CREATE,  '1,            1'b1, '1, '1, 1'b1);
      add_directed(REQ_CREATE,  '1,            1'b1, '0, '0, 1'b0);
      add_directed(REQ_CREATE,  32'd1,         1'b0, '0, '0, 1'b0);
      add_directed(REQ_CREATE,  32'd1,         1'b1, '0, '0, 1'b0);
      add_directed(REQ_COMMAND, '1,            1'b1, '1, '0, 1'b1);
      add_directed(REQ_COMMAND, 32'h1234_5678, 1'b1, '0, '0, 1'b0);
      add_directed(REQ_COMMAND, '1,            1'b0, '0, '0, 1'b0);
      add_directed(REQ_DESTROY, '0,            1'b1, '0, '0, 1'b0);
      add_directed(REQ_COMMAND, '0,            1'b1, '0, '0, 1'b0);
      add_directed(REQ_DESTROY, 32'd1,         1'b0, '0, '0, 1'b0);
      add_directed(REQ_DESTROY, 32'd1,         1'b1, '0, '0, 1'b0);
      add_directed(REQ_DESTROY, 32'd1,         1'b1, '0, '0, 1'b0);
      add_directed(REQ_CREATE,  32'h8000_0000, 1'b1, '0, '0, 1'b0);
      add_directed(REQ_DESTROY, '1,            1'b1, '0, '0, 1'b0);
      add_directed(REQ_CREATE,  32'h5555_AAAA, 1'b1, '0, '0, 1'b0);
      add_directed(REQ_POLL,    '1,            1'b0, '0, '1, 1'b0);
      add_directed(REQ_POLL,    '0,            1'b1, '1, '1, 1'b1);
      add_directed(REQ_POLL,    '0,            1'b0, '1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      add_directed(REQ_POLL,    '1,            1'b1, '1, '1, 1'b0);
      add_directed(REQ_POLL,    '0,            1'b0, 64'd1, '0, 1'b0);
      add_directed(REQ_POLL,    '0,            1'b0, 64'd1, '1, 1'b0);
      add_directed(REQ_POLL,    '0,            1'b0, 64'd5, 64'd5, 1'b1);
      add_directed(REQ_POLL,    '0,            1'b0, 64'h8000_0000_0000_0000,
                   64'h7FFF_FFFF_FFFF_FFFF, 1'b0);

      wait_all_taken();
      @(posedge clock);
      add_random(400);

      // sender idles; fill the table past capacity, then mixed traffic on a full table
      wait_all_taken();
      @(posedge clock);
      send_idle_pct = 49;
      for (int i = 0; i < SLOTS + 2; i++) begin
         stray_ids.push_back(fresh_id());
         add_directed(REQ_CREATE, stray_ids[$], 1'b1, {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom_range(1)));
      end
      add_random(200);

      // sender pauses until everything is back, then the receiver holds off
      // long enough for the block to back up and stall its input
      wait_all_replied();
      @(posedge clock);
      send_idle_pct = 0;
      hold_asks++;
      add_random(12);

      // receiver stalls; drain the table
      wait_all_taken();
      @(posedge clock);
      recv_stall_pct = 49;
      for (int i = 0; i < POOL_SIZE; i++)
         add_directed(REQ_DESTROY, id_pool[i], 1'b1, {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom_range(1)));
      foreach (stray_ids[i])
         add_directed(REQ_DESTROY, stray_ids[i], 1'b1, {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom_range(1)));
      stray_ids.delete();
      add_random(250);

      wait_all_taken();
      @(posedge clock);
      send_idle_pct = 26;
      recv_stall_pct = 26;
      add_random(560);

      wait_all_taken();
      n = 0;
      while (awaited_replies.size() != 0 && n < 20000) begin
         @(negedge clock);
         n++;
      end
      repeat (SCAN_WAIT) @(negedge clock);
      if (awaited_replies.size() != 0) begin
         error_count++;
         $display("%0t: %0d replies never arrived, next expected %p", $time,
                  awaited_replies.size(), awaited_replies[0]);
      end
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
